>>> rtl/core/wrist_pair_steering_angle_core_defines.svh
// Assertion macros shared by the steering angle core.
// Define ASSERT_OFF to compile the checks away.
`ifndef WRIST_PAIR_STEERING_ANGLE_CORE_DEFINES_SVH
`define WRIST_PAIR_STEERING_ANGLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever ante holds, cons holds in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Whenever ante holds, cons holds in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/wpsa_pkg.sv
package wpsa_pkg;

  // Default build parameters.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;

  // Angles are degrees in Q9.7; the CORDIC angle accumulator is Q.16.
  localparam int ANG_W      = 16;
  localparam int Z_W        = ANG_W + 9;
  localparam int ATAN_W     = 22;
  localparam int ATAN_IDX_W = 5;
  localparam int ANG_LIMIT  = 23040;
  localparam int Z_QUARTER  = 90 * 65536;

  // Serial multiplier operand widths.
  localparam int GAIN_W   = 12;
  localparam int WEIGHT_W = 9;
  localparam int PROD_W   = 28;
  localparam int EMA_W    = 26;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE    = 2'd0,
    REG_SENSITIVITY = 2'd1,
    REG_CALIBRATION = 2'd2,
    REG_SMOOTHING   = 2'd3
  } cfg_reg_t;

  // Arctangent of 2^-i in degrees, Q.16.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/wrist_pair_steering_angle_core.sv
// Steering angle from a pair of wrists. Each input request carries one camera
// frame: the tracked hand count and found flags in tuser, and the left and
// right wrist coordinates (Q2.14) in tdata. When two or more hands and both wrists are
// present, the angle of the vector from the left to the right wrist is found
// by a CORDIC vectoring unit that performs one micro-rotation per cycle, the
// calibration offset is removed, a deadzone is applied and the result is scaled
// by the sensitivity gain through a bit-serial multiplier, one gain bit per
// cycle. An exponential moving average, itself worked out one weight bit per
// cycle, gives the smoothed angle (Q9.7 degrees) returned in one output request
// per frame. Frames are processed one at a time: a new frame is taken only
// once the sequencer is back in its idle state. The CORDIC iterations, the
// twelve gain bits and the nine weight bits set the time a full frame takes;
// a frame inside the deadzone skips the multiplier, and a frame with a
// missing wrist or no horizontal separation skips the CORDIC unit as well. A
// finished result waits in the output register while the next frame is taken.
// Configuration writes must only be issued while no frame is in flight.
`include "wrist_pair_steering_angle_core_defines.svh"

module wrist_pair_steering_angle_core
  import wpsa_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] left_wrist_x, [31:16] left_wrist_y,
  // [47:32] right_wrist_x, [63:48] right_wrist_y
  input  logic [63:0]           s_axis_tdata,
  // [1:0] hand_count, [2] left_found, [3] right_found
  input  logic [3:0]            s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] smoothed_angle
  output logic [15:0]           m_axis_tdata
);

  // The vector is scaled up by COORD_BITS guard bits; 19 bits cover the
  // coordinate difference together with the CORDIC gain.
  localparam int XW = COORD_BITS + 19;
  localparam int CNT_MAX = (CORDIC_STEPS > GAIN_W) ? CORDIC_STEPS : GAIN_W;
  localparam int CNT_W = $clog2(CNT_MAX);

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_ANG, S_RAW, S_DZ, S_GAIN, S_SCALE, S_EMA0, S_EMA, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [14:0]              deadzone_deg;
  logic [GAIN_W-1:0]        sensitivity_gain;
  logic signed [ANG_W-1:0]  calibration_offset_deg;
  logic [WEIGHT_W-1:0]      smoothing_weight;

  // Persistent angle state.
  logic signed [ANG_W-1:0]  target_angle;
  logic signed [ANG_W-1:0]  filtered_angle;

  // Working registers.
  logic [CNT_W-1:0]         cnt;
  logic signed [XW-1:0]     cx;
  logic signed [XW-1:0]     cy;
  logic signed [Z_W-1:0]    cz;
  logic signed [ANG_W-1:0]  ang;
  logic signed [ANG_W-1:0]  raw;
  logic signed [PROD_W-1:0] mcand;
  logic [GAIN_W-1:0]        mplier;
  logic signed [PROD_W-1:0] prod;
  logic signed [EMA_W-1:0]  ta_sh;
  logic signed [EMA_W-1:0]  fa_sh;
  logic [WEIGHT_W-1:0]      w_sr;
  logic [WEIGHT_W-1:0]      v_sr;
  logic signed [EMA_W-1:0]  acc;

  // Input fields.
  logic [1:0]               hand_count;
  logic                     left_found;
  logic                     right_found;
  logic signed [15:0]       left_wrist_x;
  logic signed [15:0]       left_wrist_y;
  logic signed [15:0]       right_wrist_x;
  logic signed [15:0]       right_wrist_y;

  assign hand_count    = s_axis_tuser[1:0];
  assign left_found    = s_axis_tuser[2];
  assign right_found   = s_axis_tuser[3];
  assign left_wrist_x  = s_axis_tdata[15:0];
  assign left_wrist_y  = s_axis_tdata[31:16];
  assign right_wrist_x = s_axis_tdata[47:32];
  assign right_wrist_y = s_axis_tdata[63:48];

  logic in_acc;
  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Wrist difference and its scaled form for the CORDIC start.
  logic signed [16:0]    dx;
  logic signed [16:0]    dy;
  logic signed [XW-1:0]  dx_w;
  logic signed [XW-1:0]  dy_w;
  logic                  pair_ok;

  assign dx = {right_wrist_x[15], right_wrist_x} - {left_wrist_x[15], left_wrist_x};
  assign dy = {right_wrist_y[15], right_wrist_y} - {left_wrist_y[15], left_wrist_y};
  assign dx_w = XW'(dx) <<< COORD_BITS;
  assign dy_w = XW'(dy) <<< COORD_BITS;
  assign pair_ok = hand_count[1] && left_found && right_found;

  // One CORDIC micro-rotation.
  logic signed [XW-1:0]  x_sh;
  logic signed [XW-1:0]  y_sh;
  logic signed [Z_W-1:0] z_step;

  assign x_sh = cx >>> cnt;
  assign y_sh = cy >>> cnt;
  assign z_step = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q16(ATAN_IDX_W'(cnt))});

  // Rounding of the accumulated angle from Q.16 to Q9.7.
  logic signed [Z_W-1:0] z_round;
  assign z_round = cz + Z_W'(256);

  // Offset removal and clamp.
  logic signed [16:0]      diff;
  logic signed [ANG_W-1:0] raw_next;

  assign diff = {ang[15], ang} - {calibration_offset_deg[15], calibration_offset_deg};

  always_comb begin
    if (diff > $signed(17'(ANG_LIMIT))) begin
      raw_next = ANG_W'(ANG_LIMIT);
    end else if (diff < $signed(-17'(ANG_LIMIT))) begin
      raw_next = -ANG_W'(ANG_LIMIT);
    end else begin
      raw_next = diff[ANG_W-1:0];
    end
  end

  // Deadzone test on the magnitude.
  logic [ANG_W-1:0] mag;
  logic             in_dz;
  assign mag = raw[ANG_W-1] ? ANG_W'(-raw) : ANG_W'(raw);
  assign in_dz = mag < {1'b0, deadzone_deg};

  // Rounded and clamped gain product.
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [PROD_W-9:0]   prod_sh;
  logic signed [ANG_W-1:0]    scaled;

  assign prod_rnd = prod + PROD_W'(128);
  assign prod_sh = prod_rnd[PROD_W-1:8];

  always_comb begin
    if (prod_sh > $signed((PROD_W-8)'(ANG_LIMIT))) begin
      scaled = ANG_W'(ANG_LIMIT);
    end else if (prod_sh < $signed(-(PROD_W-8)'(ANG_LIMIT))) begin
      scaled = -ANG_W'(ANG_LIMIT);
    end else begin
      scaled = prod_sh[ANG_W-1:0];
    end
  end

  // Moving average weights; a weight above 1.0 saturates.
  logic [WEIGHT_W-1:0] w_sat;
  logic [WEIGHT_W-1:0] v_sat;
  assign w_sat = smoothing_weight[WEIGHT_W-1] ? WEIGHT_W'(256) : smoothing_weight;
  assign v_sat = WEIGHT_W'(256) - w_sat;

  logic signed [EMA_W-1:0] ema_add;
  logic signed [EMA_W-1:0] ema_rnd;
  assign ema_add = (w_sr[0] ? ta_sh : '0) + (v_sr[0] ? fa_sh : '0);
  assign ema_rnd = acc + EMA_W'(128);

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_deg           <= '0;
      sensitivity_gain       <= GAIN_W'(256);
      calibration_offset_deg <= '0;
      smoothing_weight       <= WEIGHT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEADZONE:    deadzone_deg           <= cfg_wdata[14:0];
        REG_SENSITIVITY: sensitivity_gain       <= cfg_wdata[GAIN_W-1:0];
        REG_CALIBRATION: calibration_offset_deg <= cfg_wdata;
        REG_SMOOTHING:   smoothing_weight       <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with its datapath registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_axis_tvalid  <= 1'b0;
      target_angle   <= '0;
      filtered_angle <= '0;
      cnt            <= '0;
    end else begin
      // In S_OUT the output register is reloaded instead.
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cnt <= '0;
            if (!pair_ok) begin
              target_angle <= '0;
              state        <= S_EMA0;
            end else if (dx == '0) begin
              // No horizontal separation: the last target stands.
              state <= S_EMA0;
            end else begin
              // The left half plane is turned by a quarter first.
              if (dx[16]) begin
                if (!dy[16]) begin
                  cx <= dy_w;
                  cy <= -dx_w;
                  cz <= Z_W'(Z_QUARTER);
                end else begin
                  cx <= -dy_w;
                  cy <= dx_w;
                  cz <= -Z_W'(Z_QUARTER);
                end
              end else begin
                cx <= dx_w;
                cy <= dy_w;
                cz <= '0;
              end
              state <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (!cy[XW-1]) begin
            cx <= cx + y_sh;
            cy <= cy - x_sh;
            cz <= cz + z_step;
          end else begin
            cx <= cx - y_sh;
            cy <= cy + x_sh;
            cz <= cz - z_step;
          end
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_ANG;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ANG: begin
          ang   <= z_round[Z_W-1:9];
          state <= S_RAW;
        end
        S_RAW: begin
          raw   <= raw_next;
          state <= S_DZ;
        end
        S_DZ: begin
          if (in_dz) begin
            target_angle <= '0;
            state        <= S_EMA0;
          end else begin
            mcand  <= PROD_W'(raw);
            mplier <= sensitivity_gain;
            prod   <= '0;
            cnt    <= '0;
            state  <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          if (cnt == CNT_W'(GAIN_W - 1)) begin
            cnt   <= '0;
            state <= S_SCALE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCALE: begin
          target_angle <= scaled;
          state        <= S_EMA0;
        end
        S_EMA0: begin
          ta_sh <= EMA_W'(target_angle);
          fa_sh <= EMA_W'(filtered_angle);
          w_sr  <= w_sat;
          v_sr  <= v_sat;
          acc   <= '0;
          cnt   <= '0;
          state <= S_EMA;
        end
        S_EMA: begin
          acc   <= acc + ema_add;
          ta_sh <= ta_sh <<< 1;
          fa_sh <= fa_sh <<< 1;
          w_sr  <= w_sr >> 1;
          v_sr  <= v_sr >> 1;
          if (cnt == CNT_W'(WEIGHT_W - 1)) begin
            cnt   <= '0;
            state <= S_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          // The result waits here only while the previous one is untaken.
          if (!m_axis_tvalid || m_axis_tready) begin
            filtered_angle <= ema_rnd[ANG_W+7:8];
            m_axis_tdata   <= ema_rnd[ANG_W+7:8];
            m_axis_tvalid  <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_one_frame, in_acc, !s_axis_tready, "a second frame was taken while busy")
  `ASSERT_IMPL(a_out_source, $rose(m_axis_tvalid), $past(state == S_OUT), "result without a finished frame")
  `ASSERT_ALWAYS(a_target_range, (target_angle <= $signed(ANG_W'(ANG_LIMIT))) && (target_angle >= -$signed(ANG_W'(ANG_LIMIT))), "target angle out of range")
  `ASSERT_ALWAYS(a_filter_range, (filtered_angle <= $signed(ANG_W'(ANG_LIMIT))) && (filtered_angle >= -$signed(ANG_W'(ANG_LIMIT))), "smoothed angle out of range")

endmodule
